[rtl/plist_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; every other file imports this package.
package plist_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 9;
	localparam int VAL_W    = 32;
	localparam int LEN_W    = 9;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QFILL_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		BK_RUN,
		BK_DUMP
	} back_state_t;

	// one classified command word, as held in the queue
	typedef struct packed {
		cmd_t             cmd;
		logic             pos_zero;
		logic [POS_W-1:0] pos;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} op_t;

endpackage

[rtl/plist_front.sv]
// Front end: accept command words, classify them and hold them in a short queue.
// Depends on plist_pkg.
module plist_front import plist_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  logic [1:0]              cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    head_valid,
	output op_t                     head,
	input  logic                    head_pop
);

	op_t                entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               push;
	logic               pop;
	op_t                op_w;
	logic [POS_W-1:0]   pos_m1;

	// decode: zero position flag and zero-based cell index
	always_comb begin
		pos_m1         = position - POS_W'(1);
		op_w.cmd       = cmd_t'(cmd);
		op_w.pos_zero  = (position == '0);
		op_w.pos       = position;
		op_w.idx       = pos_m1[IDX_W-1:0];
		op_w.value     = value;
	end

	assign cmd_ready  = (fill_q != QFILL_W'(QDEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign push       = cmd_valid && cmd_ready;
	assign pop        = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= op_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/plist_back.sv]
// Back end: list cells, element count, command execution and result register.
// Depends on plist_pkg; fed by plist_front.
module plist_back import plist_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  op_t                     head,
	output logic                    head_pop,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic signed [VAL_W-1:0] item_value,
	output logic [1:0]              status,
	output logic [LEN_W-1:0]        length,
	output logic                    last
);

	logic [VAL_W-1:0] cells_q [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W-1:0] dump_idx_q;
	logic [IDX_W-1:0] dump_idx_d;
	back_state_t      state_q;
	back_state_t      state_d;

	logic             res_valid_q;
	logic [VAL_W-1:0] res_value_q;
	status_t          res_status_q;
	logic [LEN_W-1:0] res_len_q;
	logic             res_last_q;

	logic             load;
	logic [VAL_W-1:0] load_value;
	status_t          load_status;
	logic             load_last;
	logic             do_ins;
	logic             do_del;
	logic             can_load;
	logic [POS_W:0]   cnt_w;
	logic [POS_W:0]   pos_w;
	logic             ins_pos_ok;
	logic             acc_pos_ok;
	logic             full;
	logic [IDX_W-1:0] rd_idx;
	logic [VAL_W-1:0] rd_data;
	logic             dump_end;

	assign can_load   = !res_valid_q || result_ready;
	assign cnt_w      = (POS_W + 1)'(count_q);
	assign pos_w      = {1'b0, head.pos};
	assign ins_pos_ok = !head.pos_zero && (pos_w <= cnt_w + (POS_W + 1)'(1));
	assign acc_pos_ok = !head.pos_zero && (pos_w <= cnt_w);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign rd_idx     = (state_q == BK_DUMP) ? dump_idx_q : head.idx;
	assign rd_data    = cells_q[rd_idx];
	assign dump_end   = (CNT_W'(dump_idx_q) + CNT_W'(1) == count_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		dump_idx_d  = dump_idx_q;
		head_pop    = 1'b0;
		load        = 1'b0;
		load_value  = '0;
		load_status = ST_OK;
		load_last   = 1'b1;
		do_ins      = 1'b0;
		do_del      = 1'b0;
		case (state_q)
			BK_RUN: begin
				if (head_valid && can_load) begin
					head_pop = 1'b1;
					case (head.cmd)
						CMD_INSERT: begin
							load = 1'b1;
							if (!ins_pos_ok) begin
								load_status = ST_BADPOS;
							end else if (full) begin
								load_status = ST_FULL;
							end else begin
								do_ins  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_DELETE: begin
							load = 1'b1;
							if (!acc_pos_ok) begin
								load_status = ST_BADPOS;
							end else begin
								do_del  = 1'b1;
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_READ: begin
							load = 1'b1;
							if (!acc_pos_ok) begin
								load_status = ST_BADPOS;
							end else begin
								load_value = rd_data;
							end
						end
						default: begin
							if (count_q == '0) begin
								load        = 1'b1;
								load_status = ST_EMPTY;
							end else begin
								state_d    = BK_DUMP;
								dump_idx_d = '0;
							end
						end
					endcase
				end
			end
			BK_DUMP: begin
				if (can_load) begin
					load       = 1'b1;
					load_value = rd_data;
					load_last  = dump_end;
					dump_idx_d = dump_idx_q + IDX_W'(1);
					if (dump_end) begin
						state_d = BK_RUN;
					end
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	// cells shift as one row: up on insert, down on delete
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic [VAL_W-1:0] below;
		logic [VAL_W-1:0] above;
		if (j == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cells_q[j-1];
		end
		if (j == CAPACITY - 1) begin : g_top
			assign above = '0;
		end else begin : g_mid_hi
			assign above = cells_q[j+1];
		end
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (IDX_W'(j) == head.idx) begin
					cells_q[j] <= head.value;
				end else if (IDX_W'(j) > head.idx) begin
					cells_q[j] <= below;
				end
			end else if (do_del && (IDX_W'(j) >= head.idx)) begin
				cells_q[j] <= above;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			count_q     <= '0;
			dump_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			dump_idx_q <= dump_idx_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_value_q  <= load_value;
			res_status_q <= load_status;
			res_len_q    <= LEN_W'(count_d);
			res_last_q   <= load_last;
		end
	end

	assign result_valid = res_valid_q;
	assign item_value   = res_value_q;
	assign status       = res_status_q;
	assign length       = res_len_q;
	assign last         = res_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DUMP) |-> (CNT_W'(dump_idx_q) < count_q))
		else $error("dump index past end of list");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list by one");

	a_no_pop_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DUMP) |-> !head_pop)
		else $error("queue popped during dump");
`endif

endmodule

[rtl/positional_list_engine.sv]
// Flow: with the queue empty, an accepted word is loaded from its queue entry into the result
// register; the first word of a dump passes the dump state first. Insert, delete, read and
// errors load one word each; a dump gives one result per cycle (cell read mux) unless stalled.
// A two-word queue parts input and back end, so two more words are taken while a dump streams.
// Reset (arst_n low, asynchronous): list empties, queue clears, result valid drops.
// Depends on plist_pkg, plist_front and plist_back.
module positional_list_engine import plist_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  logic [1:0]              cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	// result channel
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic signed [VAL_W-1:0] item_value,
	output logic [1:0]              status,
	output logic [LEN_W-1:0]        length,
	output logic                    last
);

	// queue head between the two halves
	op_t  head;
	logic head_valid;
	logic head_pop;

	// front: decode position, hold words until the back end takes them
	plist_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	// back: check positions against the count, shift cells, stream results
	plist_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.head_pop     (head_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.item_value   (item_value),
		.status       (status),
		.length       (length),
		.last         (last)
	);

endmodule

[dv/testbench.sv]
// Self-checking bench for positional_list_engine: directed rows, then random command words.
// Checks each result word against a shadow list kept in this file or a typed row's word.
// Depends on plist_pkg and the RTL of positional_list_engine.
module testbench;
	import plist_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one result word as the block should present it
	typedef struct {
		logic signed [VAL_W-1:0] val;
		status_t                 st;
		logic [LEN_W-1:0]        len;
		logic                    lst;
	} list_word_t;

	// one directed row; typed rows carry their single expected result word
	typedef struct {
		cmd_t                    c;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] v;
		bit                      typed;
		logic signed [VAL_W-1:0] e_val;
		status_t                 e_st;
		logic [LEN_W-1:0]        e_len;
	} directed_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam int RANDOM_WORDS = 400;
	localparam int HOLD_CYCLES  = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    cmd_valid;
	logic                    cmd_ready;
	logic [1:0]              cmd;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic                    result_valid;
	logic                    result_ready;
	logic signed [VAL_W-1:0] item_value;
	logic [1:0]              status;
	logic [LEN_W-1:0]        length;
	logic                    last;

	// shadow copy of the list and its length
	logic signed [VAL_W-1:0] shadow_list [CAPACITY];
	int                      shadow_count;

	// result words still owed by the block, oldest first
	list_word_t              owed_words [$];
	int                      mismatch_count;
	bit                      hold_req;

	// Right after reset, extremes and errors; list after row 11 is -1, min, max, 0.
	directed_row_t directed_words [NUM_DIRECTED] = '{
		'{CMD_DUMP,   9'd0,   32'sd0,          1'b1, 32'sd0,          ST_EMPTY,  9'd0},
		'{CMD_READ,   9'd1,   32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd0},
		'{CMD_DELETE, 9'd0,   32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd0},
		'{CMD_DELETE, 9'd1,   32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd0},
		'{CMD_INSERT, 9'd0,   32'sd5,          1'b1, 32'sd0,          ST_BADPOS, 9'd0},
		'{CMD_INSERT, 9'd2,   32'sd6,          1'b1, 32'sd0,          ST_BADPOS, 9'd0},
		'{CMD_INSERT, 9'd1,   32'sh8000_0000,  1'b1, 32'sd0,          ST_OK,     9'd1},
		'{CMD_INSERT, 9'd2,   32'sh7fff_ffff,  1'b1, 32'sd0,          ST_OK,     9'd2},
		'{CMD_INSERT, 9'd1,   -32'sd1,         1'b1, 32'sd0,          ST_OK,     9'd3},
		'{CMD_INSERT, 9'd5,   32'sd9,          1'b1, 32'sd0,          ST_BADPOS, 9'd3},
		'{CMD_INSERT, 9'd4,   32'sd0,          1'b1, 32'sd0,          ST_OK,     9'd4},
		'{CMD_READ,   9'd1,   32'sd0,          1'b1, -32'sd1,         ST_OK,     9'd4},
		'{CMD_READ,   9'd2,   32'sd0,          1'b1, 32'sh8000_0000,  ST_OK,     9'd4},
		'{CMD_READ,   9'd3,   32'sd0,          1'b1, 32'sh7fff_ffff,  ST_OK,     9'd4},
		'{CMD_READ,   9'd4,   -32'sd1,         1'b1, 32'sd0,          ST_OK,     9'd4},
		'{CMD_READ,   9'd5,   32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd4},
		'{CMD_READ,   9'd511, 32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd4},
		'{CMD_DUMP,   9'd511, 32'sh5a5a_5a5a,  1'b0, 32'sd0,          ST_OK,     9'd0},
		'{CMD_DELETE, 9'd2,   32'sd0,          1'b1, 32'sd0,          ST_OK,     9'd3},
		'{CMD_DELETE, 9'd4,   32'sd0,          1'b1, 32'sd0,          ST_BADPOS, 9'd3},
		'{CMD_INSERT, 9'd511, 32'sh5555_5555,  1'b1, 32'sd0,          ST_BADPOS, 9'd3},
		'{CMD_INSERT, 9'd2,   32'shaaaa_aaaa,  1'b0, 32'sd0,          ST_OK,     9'd0},
		'{CMD_DUMP,   9'd0,   32'sd0,          1'b0, 32'sd0,          ST_OK,     9'd0},
		'{CMD_DELETE, 9'd1,   32'sd0,          1'b0, 32'sd0,          ST_OK,     9'd0},
		'{CMD_DUMP,   9'd0,   32'sd0,          1'b0, 32'sd0,          ST_OK,     9'd0}
	};

	positional_list_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.position     (position),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.item_value   (item_value),
		.status       (status),
		.length       (length),
		.last         (last)
	);

	// free-running 50 MHz clock
	always #10 clk = ~clk;

	// Work out the result words one command causes and advance the shadow list.
	function automatic void list_command(input cmd_t c, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] v, ref list_word_t words [$]);
		int p;
		p = int'(pos);
		words = {};
		case (c)
			CMD_INSERT: begin
				if (p < 1 || p > shadow_count + 1)
					words.push_back('{0, ST_BADPOS, LEN_W'(shadow_count), 1'b1});
				else if (shadow_count >= CAPACITY)
					words.push_back('{0, ST_FULL, LEN_W'(shadow_count), 1'b1});
				else begin
					// open a gap at the position, shifting later values up
					for (int j = shadow_count; j > p - 1; j--)
						shadow_list[j] = shadow_list[j-1];
					shadow_list[p-1] = v;
					shadow_count++;
					words.push_back('{0, ST_OK, LEN_W'(shadow_count), 1'b1});
				end
			end
			CMD_DELETE: begin
				if (p < 1 || p > shadow_count)
					words.push_back('{0, ST_BADPOS, LEN_W'(shadow_count), 1'b1});
				else begin
					// close the gap
					for (int j = p - 1; j + 1 < shadow_count; j++)
						shadow_list[j] = shadow_list[j+1];
					shadow_count--;
					words.push_back('{0, ST_OK, LEN_W'(shadow_count), 1'b1});
				end
			end
			CMD_READ: begin
				if (p < 1 || p > shadow_count)
					words.push_back('{0, ST_BADPOS, LEN_W'(shadow_count), 1'b1});
				else
					words.push_back('{shadow_list[p-1], ST_OK, LEN_W'(shadow_count), 1'b1});
			end
			default: begin
				if (shadow_count == 0)
					words.push_back('{0, ST_EMPTY, '0, 1'b1});
				else
					for (int j = 0; j < shadow_count; j++)
						words.push_back('{shadow_list[j], ST_OK, LEN_W'(shadow_count),
							j + 1 == shadow_count});
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Idle length before the next command word: mostly none, some short, a few long.
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Draw a command by weight; whatever weight remains goes to dump.
	function automatic cmd_t pick_cmd(input int w_ins, input int w_del, input int w_rd);
		int r;
		r = $urandom_range(0, 99);
		if (r < w_ins)
			return CMD_INSERT;
		if (r < w_ins + w_del)
			return CMD_DELETE;
		if (r < w_ins + w_del + w_rd)
			return CMD_READ;
		return CMD_DUMP;
	endfunction

	// Mostly a legal position, the rest on and past the edges or anywhere.
	function automatic logic [POS_W-1:0] pick_position(input cmd_t c);
		int hi;
		int r;
		hi = (c == CMD_INSERT) ? shadow_count + 1 : shadow_count;
		r = $urandom_range(0, 99);
		if (c == CMD_DUMP)
			return POS_W'($urandom());
		if (r < 75 && hi >= 1)
			return POS_W'($urandom_range(1, hi));
		if (r < 85)
			return '0;
		if (r < 92)
			return POS_W'(hi + 1);
		return POS_W'($urandom_range(0, 511));
	endfunction

	// Offer one command word, hold it until accepted, then book its results.
	task automatic send_word(input cmd_t c, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] v, input int gap, input bit typed,
			input list_word_t typed_word);
		list_word_t words [$];
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		position  <= pos;
		value     <= v;
		do
			@(posedge clk);
		while (!cmd_ready);
		list_command(c, pos, v, words);
		if (typed)
			words = '{typed_word};
		foreach (words[k])
			owed_words.push_back(words[k]);
	endtask

	task automatic send_random(input int w_ins, input int w_del, input int w_rd,
			input bit quiet);
		cmd_t       c;
		list_word_t none;
		none = '{0, ST_OK, '0, 1'b0};
		c = pick_cmd(w_ins, w_del, w_rd);
		send_word(c, pick_position(c), $urandom(), pick_gap(quiet), 1'b0, none);
	endtask

	// Result side: check every accepted word against the oldest owed one.
	always @(posedge clk) begin
		list_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (owed_words.size() == 0)
				report_mismatch("word with nothing owed", item_value, 0);
			else begin
				want = owed_words.pop_front();
				if (item_value !== want.val)
					report_mismatch("item_value", item_value, want.val);
				if (status !== want.st)
					report_mismatch("status", 32'(status), 32'(want.st));
				if (length !== want.len)
					report_mismatch("length", 32'(length), 32'(want.len));
				if (last !== want.lst)
					report_mismatch("last", 32'(last), 32'(want.lst));
			end
		end
	end

	// Result side back-pressure: short stalls, a few long ones, calm stretches,
	// and one long hold-off on request so the block fills and stalls its input.
	initial begin
		int  hold_left;
		int  calm_left;
		int  stall_left;
		bit  hold_done;
		int  r;
		hold_left    = 0;
		calm_left    = 0;
		stall_left   = 0;
		hold_done    = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				result_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 2)
					calm_left = $urandom_range(50, 150);
				else if (r < 18)
					stall_left = $urandom_range(0, 2);
				else if (r < 21)
					stall_left = $urandom_range(8, 20);
			end
		end
	end

	// Command side: reset, directed rows, then random segments.
	initial begin
		list_word_t row_word;
		int         sent;
		int         extra;
		bit         full_seen;
		bit         quiet;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = CMD_INSERT;
		position       = '0;
		value          = '0;
		hold_req       = 1'b0;
		mismatch_count = 0;
		shadow_count   = 0;
		foreach (shadow_list[k])
			shadow_list[k] = '0;
		sent      = 0;
		extra     = 0;
		full_seen = 0;
		quiet     = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: edges, each command and the bad-position and empty errors
		foreach (directed_words[i]) begin
			row_word = '{directed_words[i].e_val, directed_words[i].e_st,
				directed_words[i].e_len, 1'b1};
			send_word(directed_words[i].c, directed_words[i].pos, directed_words[i].v,
				pick_gap(0), directed_words[i].typed, row_word);
		end

		// fill: mostly inserts until the list is full, then push on into it
		while (!(full_seen && extra >= 15)) begin
			if (sent % 25 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_random(85, 5, 7, quiet);
			sent++;
			if (full_seen)
				extra++;
			if (shadow_count == CAPACITY)
				full_seen = 1;
		end

		// long hold-off on the result side while words keep coming back to back
		hold_req <= 1'b1;
		repeat (40) begin
			send_random(30, 20, 35, 1);
			sent++;
		end

		// pause the input until every owed word has come out
		cmd_valid <= 1'b0;
		while (owed_words.size() != 0)
			@(posedge clk);

		// drain: mostly deletes down to an empty list, then a few more
		extra = 0;
		while (!(shadow_count == 0 && extra >= 10)) begin
			if (sent % 25 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_random(5, 80, 10, quiet);
			sent++;
			if (shadow_count == 0)
				extra++;
		end

		// mixed traffic for the rest
		while (sent < RANDOM_WORDS) begin
			if (sent % 25 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_random(38, 28, 26, quiet);
			sent++;
		end

		cmd_valid <= 1'b0;
		while (owed_words.size() != 0)
			@(posedge clk);
		// let any stray word surface
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
